### rtl/core/cfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SYNC1_RESET = 8'hA5;
  localparam logic [7:0] SYNC2_RESET = 8'h5A;
  localparam logic [7:0] END_RESET   = 8'hFF;

  typedef enum logic [1:0] {
    REG_SYNC1 = 2'd0,
    REG_SYNC2 = 2'd1,
    REG_END   = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_ACCEPT  = 3'd2,
    EV_CRCBAD  = 3'd3,
    EV_NOEND   = 3'd4
  } event_t;

  typedef enum logic [7:0] {
    PH_SYNC1 = 8'b0000_0001,
    PH_SYNC2 = 8'b0000_0010,
    PH_LEN   = 8'b0000_0100,
    PH_CMD   = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_CRCH  = 8'b0010_0000,
    PH_CRCL  = 8'b0100_0000,
    PH_END   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] sync1;
    logic [7:0] sync2;
    logic [7:0] end_val;
  } cfg_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
  } result_t;

  // CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    begin
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/cfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module cfd_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_en,
  input  wire logic [7:0]     rx_byte,
  input  wire cfd_pkg::cfg_t  cfg,
  output cfd_pkg::result_t    res
);

  cfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crch_r, crch_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [7:0]      cnt_r, cnt_nxt;

  logic [15:0]     crc_run;
  logic [15:0]     crc_fresh;
  logic            is_sync1;
  cfd_pkg::phase_t resync_phase;
  logic [15:0]     resync_crc;
  logic [7:0]      cnt_inc;
  cfd_pkg::event_t ev;

  assign crc_run   = cfd_pkg::crc_feed(crc_r, rx_byte);
  assign crc_fresh = cfd_pkg::crc_feed(cfd_pkg::CRC_INIT, rx_byte);
  assign is_sync1  = (rx_byte == cfg.sync1);
  assign resync_phase = is_sync1 ? cfd_pkg::PH_SYNC2 : cfd_pkg::PH_SYNC1;
  assign resync_crc   = is_sync1 ? crc_fresh : cfd_pkg::CRC_INIT;
  assign cnt_inc      = cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    crch_nxt  = crch_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    ev        = cfd_pkg::EV_NONE;
    case (phase_r)
      cfd_pkg::PH_SYNC1: begin
        phase_nxt = resync_phase;
        crc_nxt   = resync_crc;
      end
      cfd_pkg::PH_SYNC2: begin
        if (rx_byte == cfg.sync2) begin
          phase_nxt = cfd_pkg::PH_LEN;
          crc_nxt   = crc_run;
        end else begin
          phase_nxt = resync_phase;
          crc_nxt   = resync_crc;
        end
      end
      cfd_pkg::PH_LEN: begin
        len_nxt   = rx_byte;
        crc_nxt   = crc_run;
        phase_nxt = cfd_pkg::PH_CMD;
      end
      cfd_pkg::PH_CMD: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = crc_run;
        cnt_nxt   = 8'd0;
        phase_nxt = (len_r == 8'd0) ? cfd_pkg::PH_CRCH : cfd_pkg::PH_DATA;
      end
      cfd_pkg::PH_DATA: begin
        ev      = cfd_pkg::EV_PAYLOAD;
        crc_nxt = crc_run;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = cfd_pkg::PH_CRCH;
        end
      end
      cfd_pkg::PH_CRCH: begin
        crch_nxt  = rx_byte;
        phase_nxt = cfd_pkg::PH_CRCL;
      end
      cfd_pkg::PH_CRCL: begin
        if ({crch_r, rx_byte} == crc_r) begin
          phase_nxt = cfd_pkg::PH_END;
        end else begin
          ev        = cfd_pkg::EV_CRCBAD;
          phase_nxt = resync_phase;
          crc_nxt   = resync_crc;
        end
      end
      cfd_pkg::PH_END: begin
        if (rx_byte == cfg.end_val) begin
          ev        = cfd_pkg::EV_ACCEPT;
          phase_nxt = cfd_pkg::PH_SYNC1;
          crc_nxt   = cfd_pkg::CRC_INIT;
        end else begin
          ev        = cfd_pkg::EV_NOEND;
          phase_nxt = resync_phase;
          crc_nxt   = resync_crc;
        end
      end
      default: begin
        phase_nxt = cfd_pkg::PH_SYNC1;
        crc_nxt   = cfd_pkg::CRC_INIT;
      end
    endcase
  end

  always_comb begin
    res.event_res     = ev;
    res.payload_byte  = (ev == cfd_pkg::EV_PAYLOAD) ? rx_byte : 8'd0;
    res.payload_index = (ev == cfd_pkg::EV_PAYLOAD) ? cnt_r : 8'd0;
    res.frame_command = (ev == cfd_pkg::EV_NONE) ? 8'd0 : cmd_r;
    res.frame_length  = (ev == cfd_pkg::EV_NONE) ? 8'd0 : len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfd_pkg::PH_SYNC1;
      crc_r   <= cfd_pkg::CRC_INIT;
      crch_r  <= 8'd0;
      len_r   <= 8'd0;
      cmd_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (item_en) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      crch_r  <= crch_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cfd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module cfd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cfd_pkg::result_t  res_in,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cfd_pkg::result_t       out_res
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  cfd_pkg::result_t out_r, out_nxt;
  cfd_pkg::result_t skid_r, skid_nxt;
  logic             take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = push;
        if (push) begin
          skid_nxt = res_in;
        end
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_nxt = res_in;
        end
      end
    end else if (push) begin
      // hold the head beat, park the new one
      skid_valid_nxt = 1'b1;
      skid_nxt       = res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/crc16_frame_deframer_unit.sv
// A result beat is registered in the output buffer, in the cycle after its byte is accepted when no earlier beat waits.
// Throughput: one byte per cycle while in_stall is low; the CRC byte update and the frame state
// machine are combinational, and a two-beat output buffer stalls input only when both beats are full.
// Reset (synchronous, rst_n low): parser waits for sync one, CRC = 0xFFFF,
// sync bytes 0xA5/0x5A, end byte 0xFF, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_deframer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,

  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_event_res,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic [7:0]      out_frame_command,
  output logic [7:0]      out_frame_length,

  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfd_pkg::cfg_t    cfg_r;
  cfd_pkg::result_t res;
  cfd_pkg::result_t out_res;
  logic             buf_full;
  logic             item_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign item_en   = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync1   <= cfd_pkg::SYNC1_RESET;
      cfg_r.sync2   <= cfd_pkg::SYNC2_RESET;
      cfg_r.end_val <= cfd_pkg::END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfd_pkg::REG_SYNC1: cfg_r.sync1   <= cfg_data;
        cfd_pkg::REG_SYNC2: cfg_r.sync2   <= cfg_data;
        cfd_pkg::REG_END:   cfg_r.end_val <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (item_en),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  cfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_en),
    .res_in    (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_res     = out_res.event_res;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_frame_command = out_res.frame_command;
  assign out_frame_length  = out_res.frame_length;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result beat pending");

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte produced no result beat");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != cfd_pkg::EV_PAYLOAD) |->
      (out_payload_byte == 8'd0 && out_payload_index == 8'd0))
    else $error("payload fields nonzero outside a payload beat");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == cfd_pkg::EV_NONE) |->
      (out_frame_command == 8'd0 && out_frame_length == 8'd0))
    else $error("frame fields nonzero on an empty beat");

endmodule

`default_nettype wire

### dv/crc16_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps

module crc16_frame_deframer_unit_tb;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD = 80;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_CRC_SYNC1,
    FR_NO_END,
    FR_NO_END_SYNC1,
    FR_CUT_SHORT,
    FR_BAD_SYNC2
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [7:0] out_frame_command;
  logic [7:0] out_frame_length;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'h00;

  // parser state and register copy
  logic [7:0]       sync1_val = cfd_pkg::SYNC1_RESET;
  logic [7:0]       sync2_val = cfd_pkg::SYNC2_RESET;
  logic [7:0]       end_val = cfd_pkg::END_RESET;
  cfd_pkg::phase_t  ph = cfd_pkg::PH_SYNC1;
  logic [15:0]      crc_acc = cfd_pkg::CRC_INIT;
  logic [7:0]       crc_hi_rx = 8'h00;
  logic [7:0]       len_rx = 8'h00;
  logic [7:0]       cmd_rx = 8'h00;
  logic [7:0]       data_cnt = 8'h00;

  cfd_pkg::result_t frame_events_q[$];

  int  bytes_in = 0;
  int  beats_out = 0;
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  ev_seen[5] = '{default: 0};
  int  long_hold_req = 0;
  bit  src_gaps_on = 1'b1;
  bit  sink_stalls_on = 1'b1;
  bit  pending_sync1 = 1'b0;

  crc16_frame_deframer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[15:1]};
      if (fb) r = r ^ cfd_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic void restart_or_idle(input logic [7:0] b);
    if (b == sync1_val) begin
      crc_acc = crc16_update(cfd_pkg::CRC_INIT, b);
      ph = cfd_pkg::PH_SYNC2;
    end else begin
      crc_acc = cfd_pkg::CRC_INIT;
      ph = cfd_pkg::PH_SYNC1;
    end
  endfunction

  function automatic cfd_pkg::result_t deframe_step(input logic [7:0] b);
    cfd_pkg::result_t r;
    r = '0;
    r.event_res = cfd_pkg::EV_NONE;
    case (ph)
      cfd_pkg::PH_SYNC1: restart_or_idle(b);
      cfd_pkg::PH_SYNC2: begin
        if (b == sync2_val) begin
          crc_acc = crc16_update(crc_acc, b);
          ph = cfd_pkg::PH_LEN;
        end else begin
          restart_or_idle(b);
        end
      end
      cfd_pkg::PH_LEN: begin
        len_rx = b;
        crc_acc = crc16_update(crc_acc, b);
        ph = cfd_pkg::PH_CMD;
      end
      cfd_pkg::PH_CMD: begin
        cmd_rx = b;
        crc_acc = crc16_update(crc_acc, b);
        data_cnt = 8'h00;
        ph = (len_rx == 8'h00) ? cfd_pkg::PH_CRCH : cfd_pkg::PH_DATA;
      end
      cfd_pkg::PH_DATA: begin
        r.event_res = cfd_pkg::EV_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = data_cnt;
        crc_acc = crc16_update(crc_acc, b);
        data_cnt = data_cnt + 8'd1;
        if (data_cnt >= len_rx) ph = cfd_pkg::PH_CRCH;
      end
      cfd_pkg::PH_CRCH: begin
        crc_hi_rx = b;
        ph = cfd_pkg::PH_CRCL;
      end
      cfd_pkg::PH_CRCL: begin
        if ({crc_hi_rx, b} == crc_acc) begin
          ph = cfd_pkg::PH_END;
        end else begin
          r.event_res = cfd_pkg::EV_CRCBAD;
          restart_or_idle(b);
        end
      end
      default: begin
        if (b == end_val) begin
          r.event_res = cfd_pkg::EV_ACCEPT;
          crc_acc = cfd_pkg::CRC_INIT;
          ph = cfd_pkg::PH_SYNC1;
        end else begin
          r.event_res = cfd_pkg::EV_NOEND;
          restart_or_idle(b);
        end
      end
    endcase
    if (r.event_res != cfd_pkg::EV_NONE) begin
      r.frame_command = cmd_rx;
      r.frame_length = len_rx;
    end
    return r;
  endfunction

  always @(negedge clk) begin : monitor
    cfd_pkg::result_t want;
    bit               moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          cfd_pkg::REG_SYNC1: sync1_val = cfg_data;
          cfd_pkg::REG_SYNC2: sync2_val = cfg_data;
          cfd_pkg::REG_END:   end_val = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        frame_events_q.push_back(deframe_step(in_rx_byte));
        bytes_in++;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        beats_out++;
        if (frame_events_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing expected, ev=%0d",
                     $realtime, out_event_res);
        end else begin
          want = frame_events_q.pop_front();
          if (want.event_res <= cfd_pkg::EV_NOEND) ev_seen[want.event_res]++;
          if (out_event_res !== want.event_res || out_payload_byte !== want.payload_byte ||
              out_payload_index !== want.payload_index ||
              out_frame_command !== want.frame_command ||
              out_frame_length !== want.frame_length) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp ev=%0d byte=%02h idx=%0d cmd=%02h len=%0d,",
                        " got ev=%0d byte=%02h idx=%0d cmd=%02h len=%0d"},
                       $realtime, want.event_res, want.payload_byte, want.payload_index,
                       want.frame_command, want.frame_length, out_event_res,
                       out_payload_byte, out_payload_index, out_frame_command,
                       out_frame_length);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, frame_events_q.size());
        $display("** crc16_frame_deframer_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold_req) @(posedge clk);
        long_hold_req = 0;
        out_stall <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (frame_events_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    wait_for_drain();
    pending_sync1 = 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise(input int n);
    logic [7:0] nb;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: nb = sync1_val;
        1: nb = sync2_val;
        2: nb = end_val;
        default: nb = 8'($urandom);
      endcase
      send_byte(nb);
    end
    pending_sync1 = 1'b0;
  endtask

  task automatic send_frame(input int len, input logic [7:0] cmd, input frame_kind_t kind);
    logic [15:0] crc;
    logic [7:0]  body[$];
    logic [7:0]  bad;
    logic [7:0]  pb;
    int          cut;
    crc = crc16_update(cfd_pkg::CRC_INIT, sync1_val);
    // a restart on sync one already opened this frame
    if (!(pending_sync1 && (sync1_val == sync2_val || $urandom_range(0, 1))))
      body.push_back(sync1_val);
    pending_sync1 = 1'b0;
    if (kind == FR_BAD_SYNC2) begin
      do bad = 8'($urandom); while (bad == sync2_val);
      body.push_back(bad);
    end else begin
      body.push_back(sync2_val);
      crc = crc16_update(crc, sync2_val);
      body.push_back(len[7:0]);
      crc = crc16_update(crc, len[7:0]);
      body.push_back(cmd);
      crc = crc16_update(crc, cmd);
      for (int i = 0; i < len; i++) begin
        pb = 8'($urandom);
        body.push_back(pb);
        crc = crc16_update(crc, pb);
      end
      case (kind)
        FR_BAD_CRC: crc = crc ^ 16'($urandom_range(1, 65535));
        FR_BAD_CRC_SYNC1: begin
          if (crc[7:0] == sync1_val) crc[15:8] = ~crc[15:8];
          crc[7:0] = sync1_val;
          pending_sync1 = 1'b1;
        end
        default: ;
      endcase
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      case (kind)
        FR_BAD_CRC_SYNC1: ;
        FR_NO_END: begin
          do bad = 8'($urandom); while (bad == end_val);
          body.push_back(bad);
        end
        FR_NO_END_SYNC1: begin
          body.push_back(sync1_val);
          pending_sync1 = (sync1_val != end_val);
        end
        default: body.push_back(end_val);
      endcase
      if (kind == FR_CUT_SHORT) begin
        cut = $urandom_range(2, body.size() - 2);
        while (body.size() > cut) void'(body.pop_back());
      end
    end
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic random_unit();
    int          pick;
    int          len;
    frame_kind_t kind;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
    if (pick < 55) kind = FR_GOOD;
    else if (pick < 63) kind = FR_BAD_CRC;
    else if (pick < 68) kind = FR_BAD_CRC_SYNC1;
    else if (pick < 75) kind = FR_NO_END;
    else if (pick < 80) kind = FR_NO_END_SYNC1;
    else if (pick < 86) kind = FR_CUT_SHORT;
    else if (pick < 91) kind = FR_BAD_SYNC2;
    else begin
      send_noise($urandom_range(1, 4));
      return;
    end
    send_frame(len, 8'($urandom), kind);
  endtask

  task automatic test_random_frames(input int n);
    int stop_at;
    stop_at = bytes_in + n;
    while (bytes_in < stop_at) random_unit();
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(sync1_val);
    send_byte(8'h11);
    // repeated sync one in front of a zero-length frame
    send_byte(sync1_val);
    send_frame(0, 8'h00, FR_GOOD);
    send_frame(1, 8'hFF, FR_BAD_CRC_SYNC1);
    send_frame(0, 8'h80, FR_NO_END_SYNC1);
  endtask

  task automatic test_long_payload();
    send_frame(255, 8'($urandom), FR_GOOD);
  endtask

  task automatic test_config_sweep();
    write_reg(cfd_pkg::REG_SYNC1, 8'h00);
    write_reg(cfd_pkg::REG_SYNC2, 8'hFF);
    write_reg(cfd_pkg::REG_END, 8'h00);
    test_random_frames(12);
    write_reg(cfd_pkg::REG_SYNC1, 8'hFF);
    write_reg(cfd_pkg::REG_SYNC2, 8'h00);
    write_reg(cfd_pkg::REG_END, 8'hFF);
    test_random_frames(12);
    write_reg(cfd_pkg::REG_SYNC1, 8'h7E);
    write_reg(cfd_pkg::REG_SYNC2, 8'h7E);
    write_reg(cfd_pkg::REG_END, 8'h81);
    test_random_frames(12);
    write_reg(REG_SPARE, 8'h33);
    test_random_frames(8);
    write_reg(cfd_pkg::REG_SYNC1, 8'($urandom));
    write_reg(cfd_pkg::REG_SYNC2, 8'($urandom));
    write_reg(cfd_pkg::REG_END, 8'($urandom));
    test_random_frames(12);
    write_reg(cfd_pkg::REG_SYNC1, cfd_pkg::SYNC1_RESET);
    write_reg(cfd_pkg::REG_SYNC2, cfd_pkg::SYNC2_RESET);
    write_reg(cfd_pkg::REG_END, cfd_pkg::END_RESET);
  endtask

  task automatic test_backpressure();
    long_hold_req = LONG_HOLD;
    test_random_frames(20);
    in_valid <= 1'b0;
    wait_for_drain();
    test_random_frames(12);
  endtask

  task automatic test_steady();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    test_random_frames(25);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_frames(30);
    test_long_payload();
    test_config_sweep();
    test_backpressure();
    test_steady();
    in_valid <= 1'b0;
    wait_for_drain();
    $display({"run covered %0d bytes and %0d result beats: %0d payload, %0d accepted,",
              " %0d crc errors, %0d missing end"},
             bytes_in, beats_out, ev_seen[cfd_pkg::EV_PAYLOAD],
             ev_seen[cfd_pkg::EV_ACCEPT], ev_seen[cfd_pkg::EV_CRCBAD],
             ev_seen[cfd_pkg::EV_NOEND]);
    $display("swept sync/end values incl. equal syncs, ran a 255-byte payload and a long hold-off");
    if (fail_count == 0) begin
      $display("** crc16_frame_deframer_unit: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** crc16_frame_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
